// File: rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame decoder.
// No dependencies; the parser and the decoder core refer to this package by scoped names.

package wsfd_pkg;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One result word of the decoder
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       frame_end;
        logic       empty_frame;
        logic       close_seen;
    } result_t;

endpackage

// File: rtl/wsfd_stream_if.sv
// Valid/ready channel interfaces for the received byte stream and the results.
// Depends on nothing; used by the decoder top level.

interface wsfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsfd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       empty_frame;
    logic       close_seen;

    modport source (output valid, output data_byte, output frame_end,
                    output empty_frame, output close_seen, input ready);
    modport sink   (input valid, input data_byte, input frame_end,
                    input empty_frame, input close_seen, output ready);
endinterface

// File: rtl/wsfd_parser.sv
// Frame parser: header, extended length, mask key and payload tracking.
// Depends on wsfd_pkg; one byte is parsed per step, the result is combinational.

module wsfd_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output wsfd_pkg::result_t   res
);

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASKKEY,
        PH_PAYLOAD
    } phase_t;

    phase_t                   phase_reg,   phase_next;
    logic [3:0]               opcode_reg,  opcode_next;
    logic                     mask_reg,    mask_next;
    logic [3:0]               left_reg,    left_next;
    logic [LENGTH_BITS-1:0]   len_reg,     len_next;
    logic [LENGTH_BITS-1:0]   remain_reg,  remain_next;
    logic [31:0]              key_reg,     key_next;
    logic [1:0]               idx_reg,     idx_next;
    logic                     stopped_reg, stopped_next;

    logic                     len_done;
    logic                     hdr_done;
    logic                     last;
    logic [7:0]               key_byte;

    assign key_byte = key_reg[{~idx_reg, 3'b000} +: 8];
    assign last     = (remain_reg == LENGTH_BITS'(1));

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        remain_next  = remain_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        stopped_next = stopped_reg;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        res          = '0;

        if (step && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_next = rx_byte[7];
                    len_next  = '0;
                    if (rx_byte[6:0] == wsfd_pkg::LEN_EXT16)
                    begin
                        left_next  = wsfd_pkg::EXT16_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else if (rx_byte[6:0] == wsfd_pkg::LEN_EXT64)
                    begin
                        left_next  = wsfd_pkg::EXT64_BYTES;
                        phase_next = PH_EXTLEN;
                    end
                    else
                    begin
                        len_next = LENGTH_BITS'(rx_byte[6:0]);
                        len_done = 1'b1;
                    end
                end
                PH_EXTLEN:
                begin
                    // high bits fall off the top
                    len_next  = {len_reg[LENGTH_BITS-9:0], rx_byte};
                    left_next = left_reg - 4'd1;
                    len_done  = (left_reg == 4'd1);
                end
                PH_MASKKEY:
                begin
                    key_next  = {key_reg[23:0], rx_byte};
                    left_next = left_reg - 4'd1;
                    hdr_done  = (left_reg == 4'd1);
                end
                PH_PAYLOAD:
                begin
                    remain_next = remain_reg - LENGTH_BITS'(1);
                    idx_next    = idx_reg + 2'd1;
                    if (last)
                        phase_next = PH_HDR0;
                    if (opcode_reg == wsfd_pkg::OP_BINARY)
                    begin
                        res.valid     = 1'b1;
                        res.data_byte = mask_reg ? (rx_byte ^ key_byte) : rx_byte;
                        res.frame_end = last;
                    end
                    else if (last && opcode_reg == wsfd_pkg::OP_CLOSE)
                    begin
                        stopped_next   = 1'b1;
                        res.valid      = 1'b1;
                        res.close_seen = 1'b1;
                    end
                end
                default:
                    phase_next = PH_HDR0;
            endcase

            if (len_done)
            begin
                if (mask_next)
                begin
                    left_next  = wsfd_pkg::KEY_BYTES;
                    key_next   = '0;
                    phase_next = PH_MASKKEY;
                end
                else
                    hdr_done = 1'b1;
            end

            if (hdr_done)
            begin
                if (len_next != '0)
                begin
                    remain_next = len_next;
                    idx_next    = 2'd0;
                    phase_next  = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_HDR0;
                    if (opcode_reg == wsfd_pkg::OP_BINARY)
                    begin
                        res.valid       = 1'b1;
                        res.frame_end   = 1'b1;
                        res.empty_frame = 1'b1;
                    end
                    else if (opcode_reg == wsfd_pkg::OP_CLOSE)
                    begin
                        stopped_next   = 1'b1;
                        res.valid      = 1'b1;
                        res.close_seen = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            left_reg    <= '0;
            len_reg     <= '0;
            remain_reg  <= '0;
            key_reg     <= '0;
            idx_reg     <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            left_reg    <= left_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
            key_reg     <= key_next;
            idx_reg     <= idx_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: rtl/websocket_frame_decoder_core.sv
// Channel   | direction | word
// ----------+-----------+----------------------------------------------------
// rx        | sink      | rx_byte: next received byte of the framed stream
// frame     | source    | data_byte, frame_end, empty_frame, close_seen
//
// One byte word is taken per cycle while rx is ready; its result, if any,
// shows on frame the next cycle from the result register.
// rx stalls only while a result waits in the register and frame is not ready.
// rst_n clears the parser to the first header byte and empties the register.
// After a close event every byte is still taken and dropped until reset.
// Depends on wsfd_pkg, wsfd_stream_if and wsfd_parser.

module websocket_frame_decoder_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    wsfd_byte_if.sink            rx,
    wsfd_result_if.source        frame
);

    wsfd_pkg::result_t res;
    logic              step;
    logic              valid_reg;
    logic [7:0]        data_reg;
    logic              end_reg;
    logic              empty_reg;
    logic              close_reg;

    assign rx.ready = !valid_reg || frame.ready;
    assign step     = rx.valid && rx.ready;

    wsfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (rx.rx_byte),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= res.valid;
        else if (frame.ready)
            valid_reg <= 1'b0;
    end

    // payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            data_reg  <= res.data_byte;
            end_reg   <= res.frame_end;
            empty_reg <= res.empty_frame;
            close_reg <= res.close_seen;
        end
    end

    assign frame.valid       = valid_reg;
    assign frame.data_byte   = data_reg;
    assign frame.frame_end   = end_reg;
    assign frame.empty_frame = empty_reg;
    assign frame.close_seen  = close_reg;

endmodule
